// ===== rtl/tflpp_pkg.sv =====
// Shared constants for the top-four local peak picker.
package tflpp_pkg;

  localparam int unsigned TagWidth       = 24;
  localparam int unsigned MagWidth       = 32;
  localparam int unsigned RankWidth      = 2;
  localparam int unsigned SeenWidth      = 3;
  localparam int unsigned ResultSlots    = 4;
  localparam int unsigned MinRunPoints   = 4;
  localparam int unsigned TopCountDefault = 4;

endpackage

// ===== rtl/top_four_local_peak_picker.sv =====
// Top-four local peak picker: sorted peak list plus a four-entry result buffer.
// Latency: the first result of a run is offered the cycle after its last point is accepted.
// Throughput: one point per cycle unless a last point is held off; a run emits four results.
// A last point is held off only while the previous run's four results are still draining.
// Reset (rst_ni low, asynchronous) clears the point history and the peak list
// and empties the result buffer.
module top_four_local_peak_picker #(
  parameter int unsigned TopCount = tflpp_pkg::TopCountDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tflpp_pkg::TagWidth-1:0]   point_tag_i,
  input  logic [tflpp_pkg::MagWidth-1:0]   point_magnitude_i,
  input  logic                             last_point_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tflpp_pkg::TagWidth-1:0]   peak_tag_o,
  output logic [tflpp_pkg::MagWidth-1:0]   peak_magnitude_o,
  output logic [tflpp_pkg::RankWidth-1:0]  peak_rank_o,
  output logic                             last_peak_o
);

  localparam int unsigned TagW  = tflpp_pkg::TagWidth;
  localparam int unsigned MagW  = tflpp_pkg::MagWidth;
  localparam int unsigned RankW = tflpp_pkg::RankWidth;
  localparam int unsigned SeenW = tflpp_pkg::SeenWidth;
  localparam int unsigned Slots = tflpp_pkg::ResultSlots;
  localparam int unsigned FillW = $clog2(TopCount + 1);

  // point history and peak list
  logic [TagW-1:0]  older_tag_q, newer_tag_q;
  logic [MagW-1:0]  older_mag_q, newer_mag_q;
  logic [SeenW-1:0] seen_q, seen_d;
  logic [TagW-1:0]  best_tag_q [TopCount];
  logic [MagW-1:0]  best_mag_q [TopCount];
  logic [TagW-1:0]  best_tag_d [TopCount];
  logic [MagW-1:0]  best_mag_d [TopCount];
  logic [FillW-1:0] filled_q, filled_d;
  logic [TopCount-1:0] keep_ge;
  logic             is_peak;

  // result buffer
  logic [TagW-1:0]  res_tag_q [Slots];
  logic [MagW-1:0]  res_mag_q [Slots];
  logic [TagW-1:0]  res_tag_d [Slots];
  logic [MagW-1:0]  res_mag_d [Slots];
  logic             busy_q;
  logic [RankW-1:0] idx_q;
  logic             in_fire, out_fire, drain_done, long_run;

  assign out_fire   = busy_q && out_ready_i;
  assign drain_done = out_fire && (idx_q == RankW'(Slots - 1));
  assign in_ready_o = !last_point_i || !busy_q || drain_done;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_peak = (seen_q >= SeenW'(2)) && (newer_mag_q > older_mag_q) &&
                   (newer_mag_q > point_magnitude_i);

  // Sorted insert: kept entries at least as large stay, the candidate lands at the
  // first smaller one, and everything below shifts down one slot.
  always_comb begin
    int unsigned prev;
    for (int unsigned i = 0; i < TopCount; i++) begin
      keep_ge[i] = (FillW'(i) < filled_q) && (best_mag_q[i] >= newer_mag_q);
    end
    for (int unsigned i = 0; i < TopCount; i++) begin
      prev = (i == 0) ? 0 : i - 1;
      if (!is_peak || keep_ge[i]) begin
        best_tag_d[i] = best_tag_q[i];
        best_mag_d[i] = best_mag_q[i];
      end else if (i == 0 || keep_ge[prev]) begin
        best_tag_d[i] = newer_tag_q;
        best_mag_d[i] = newer_mag_q;
      end else begin
        best_tag_d[i] = best_tag_q[prev];
        best_mag_d[i] = best_mag_q[prev];
      end
    end
    filled_d = filled_q;
    if (is_peak && !keep_ge[TopCount-1] && (filled_q < FillW'(TopCount))) begin
      filled_d = filled_q + FillW'(1);
    end
    seen_d = seen_q;
    if (seen_q < SeenW'(tflpp_pkg::MinRunPoints)) begin
      seen_d = seen_q + SeenW'(1);
    end
  end

  assign long_run = (seen_d >= SeenW'(tflpp_pkg::MinRunPoints));

  for (genvar j = 0; j < Slots; j++) begin : g_snap
    if (j < TopCount) begin : g_live
      logic use_slot;
      assign use_slot     = long_run && (FillW'(j) < filled_d);
      assign res_tag_d[j] = use_slot ? best_tag_d[j] : '0;
      assign res_mag_d[j] = use_slot ? best_mag_d[j] : '0;
    end else begin : g_empty
      assign res_tag_d[j] = '0;
      assign res_mag_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_tag_q <= '0;
      older_mag_q <= '0;
      newer_tag_q <= '0;
      newer_mag_q <= '0;
      seen_q      <= '0;
      filled_q    <= '0;
      for (int unsigned i = 0; i < TopCount; i++) begin
        best_tag_q[i] <= '0;
        best_mag_q[i] <= '0;
      end
    end else if (in_fire) begin
      if (last_point_i) begin
        // run closes: start the next one from a clean state
        older_tag_q <= '0;
        older_mag_q <= '0;
        newer_tag_q <= '0;
        newer_mag_q <= '0;
        seen_q      <= '0;
        filled_q    <= '0;
        for (int unsigned i = 0; i < TopCount; i++) begin
          best_tag_q[i] <= '0;
          best_mag_q[i] <= '0;
        end
      end else begin
        older_tag_q <= newer_tag_q;
        older_mag_q <= newer_mag_q;
        newer_tag_q <= point_tag_i;
        newer_mag_q <= point_magnitude_i;
        seen_q      <= seen_d;
        filled_q    <= filled_d;
        best_tag_q  <= best_tag_d;
        best_mag_q  <= best_mag_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_fire && last_point_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_fire) begin
      idx_q <= idx_q + RankW'(1);
      if (drain_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_point_i) begin
      res_tag_q <= res_tag_d;
      res_mag_q <= res_mag_d;
    end
  end

  assign out_valid_o      = busy_q;
  assign peak_tag_o       = res_tag_q[idx_q];
  assign peak_magnitude_o = res_mag_q[idx_q];
  assign peak_rank_o      = idx_q;
  assign last_peak_o      = (idx_q == RankW'(Slots - 1));

endmodule

// ===== verif/peak_list_checker.sv =====
// Checker for the top-four local peak picker: predicts ranked peaks and compares results.
`timescale 1ns / 100ps

module peak_list_checker #(
  parameter int unsigned TopCount = tflpp_pkg::TopCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pt_valid_i,
  input  logic                            pt_ready_i,
  input  logic [tflpp_pkg::TagWidth-1:0]  pt_tag_i,
  input  logic [tflpp_pkg::MagWidth-1:0]  pt_mag_i,
  input  logic                            pt_last_i,
  input  logic                            pk_valid_i,
  input  logic                            pk_ready_i,
  input  logic [tflpp_pkg::TagWidth-1:0]  pk_tag_i,
  input  logic [tflpp_pkg::MagWidth-1:0]  pk_mag_i,
  input  logic [tflpp_pkg::RankWidth-1:0] pk_rank_i,
  input  logic                            pk_last_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              points_o,
  output int                              results_o
);

  typedef logic [tflpp_pkg::TagWidth-1:0] tag_t;
  typedef logic [tflpp_pkg::MagWidth-1:0] mag_t;

  typedef struct packed {
    tag_t                            tag;
    mag_t                            mag;
    logic [tflpp_pkg::RankWidth-1:0] rank;
    logic                            last;
  } peak_result_t;

  // two-point history and the sorted peak list
  tag_t prev2_tag, prev1_tag;
  mag_t prev2_mag, prev1_mag;
  int   run_points;
  tag_t kept_tag [TopCount];
  mag_t kept_mag [TopCount];
  int   kept;

  peak_result_t ranked_due[$];
  int fails, due_count, points, results;

  assign fail_count_o = fails;
  assign pending_o    = due_count;
  assign points_o     = points;
  assign results_o    = results;

  task automatic clear_run();
    prev2_tag  = '0;
    prev2_mag  = '0;
    prev1_tag  = '0;
    prev1_mag  = '0;
    run_points = 0;
    kept       = 0;
    for (int i = 0; i < TopCount; i++) begin
      kept_tag[i] = '0;
      kept_mag[i] = '0;
    end
  endtask

  // equal magnitudes keep arrival order; a full list drops anything not strictly larger
  task automatic keep_peak(input tag_t tag, input mag_t mag);
    int pos;
    int k;
    pos = 0;
    while (pos < kept && kept_mag[pos] >= mag) pos++;
    if (pos >= TopCount) return;
    k = (kept < TopCount) ? kept : TopCount - 1;
    while (k > pos) begin
      kept_tag[k] = kept_tag[k-1];
      kept_mag[k] = kept_mag[k-1];
      k--;
    end
    kept_tag[pos] = tag;
    kept_mag[pos] = mag;
    if (kept < TopCount) kept++;
  endtask

  task automatic track_point(input tag_t tag, input mag_t mag, input logic last);
    peak_result_t r;
    bit long_run;
    if (run_points >= 2 && prev1_mag > prev2_mag && prev1_mag > mag) begin
      keep_peak(prev1_tag, prev1_mag);
    end
    prev2_tag = prev1_tag;
    prev2_mag = prev1_mag;
    prev1_tag = tag;
    prev1_mag = mag;
    if (run_points < tflpp_pkg::MinRunPoints) run_points++;
    points++;
    if (!last) return;
    long_run = run_points >= tflpp_pkg::MinRunPoints;
    for (int i = 0; i < tflpp_pkg::ResultSlots; i++) begin
      r.tag  = '0;
      r.mag  = '0;
      if (long_run && i < TopCount && i < kept) begin
        r.tag = kept_tag[i];
        r.mag = kept_mag[i];
      end
      r.rank = i[tflpp_pkg::RankWidth-1:0];
      r.last = (i == tflpp_pkg::ResultSlots - 1);
      ranked_due.push_back(r);
    end
    due_count = ranked_due.size();
    clear_run();
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    fails++;
  endtask

  task automatic check_peak();
    peak_result_t want;
    results++;
    if (ranked_due.size() == 0) begin
      $display("%0t: result with nothing pending, actual tag %h magnitude %h rank %0d",
               $time, pk_tag_i, pk_mag_i, pk_rank_i);
      fails++;
      return;
    end
    want = ranked_due.pop_front();
    due_count = ranked_due.size();
    if (pk_tag_i  !== want.tag)  note_mismatch("peak_tag", want.tag, pk_tag_i);
    if (pk_mag_i  !== want.mag)  note_mismatch("peak_magnitude", want.mag, pk_mag_i);
    if (pk_rank_i !== want.rank) note_mismatch("peak_rank", want.rank, pk_rank_i);
    if (pk_last_i !== want.last) note_mismatch("last_peak", want.last, pk_last_i);
  endtask

  initial begin
    fails     = 0;
    due_count = 0;
    points    = 0;
    results   = 0;
    clear_run();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      ranked_due.delete();
      due_count = 0;
    end else begin
      if (pk_valid_i && pk_ready_i) check_peak();
      if (pt_valid_i && pt_ready_i) track_point(pt_tag_i, pt_mag_i, pt_last_i);
    end
  end

endmodule

// ===== verif/tb_top_four_local_peak_picker.sv =====
// Testbench top for the top-four local peak picker: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_top_four_local_peak_picker;

  localparam int RandomItems = 270;
  localparam int CalmAfter   = 210;
  localparam int CycleLimit  = 200000;

  typedef logic [tflpp_pkg::TagWidth-1:0] tag_t;
  typedef logic [tflpp_pkg::MagWidth-1:0] mag_t;

  typedef enum int {ShapeSmall, ShapeWide, ShapeZigzag, ShapeEdge} shape_e;

  logic clk_i        = 1'b0;
  logic rst_ni       = 1'b0;
  logic in_valid_i   = 1'b0;
  tag_t point_tag_i  = '0;
  mag_t point_magnitude_i = '0;
  logic last_point_i = 1'b0;
  logic out_ready_i  = 1'b0;

  logic                            in_ready_o;
  logic                            out_valid_o;
  tag_t                            peak_tag_o;
  mag_t                            peak_magnitude_o;
  logic [tflpp_pkg::RankWidth-1:0] peak_rank_o;
  logic                            last_peak_o;

  int fail_count, pending, points_checked, results_checked;
  int items_sent = 0;
  int runs_sent  = 0;
  int idle_odds  = 0;
  int stall_left = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  top_four_local_peak_picker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .point_tag_i       (point_tag_i),
    .point_magnitude_i (point_magnitude_i),
    .last_point_i      (last_point_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .peak_tag_o        (peak_tag_o),
    .peak_magnitude_o  (peak_magnitude_o),
    .peak_rank_o       (peak_rank_o),
    .last_peak_o       (last_peak_o)
  );

  peak_list_checker u_peak_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pt_valid_i   (in_valid_i),
    .pt_ready_i   (in_ready_o),
    .pt_tag_i     (point_tag_i),
    .pt_mag_i     (point_magnitude_i),
    .pt_last_i    (last_point_i),
    .pk_valid_i   (out_valid_o),
    .pk_ready_i   (out_ready_i),
    .pk_tag_i     (peak_tag_o),
    .pk_mag_i     (peak_magnitude_o),
    .pk_rank_i    (peak_rank_o),
    .pk_last_i    (last_peak_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .points_o     (points_checked),
    .results_o    (results_checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_point(input tag_t tag, input mag_t mag, input logic last);
    int gap;
    if (!calm && idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    point_tag_i       <= tag;
    point_magnitude_i <= mag;
    last_point_i      <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (items_sent >= CalmAfter) calm = 1'b1;
  endtask

  task automatic send_listed_run(input tag_t tag_base, input mag_t mags[$]);
    for (int i = 0; i < mags.size(); i++) begin
      send_point(tag_base + tag_t'(i), mags[i], i == mags.size() - 1);
    end
    runs_sent++;
  endtask

  function automatic mag_t pick_magnitude(input shape_e shape, input int idx);
    mag_t m;
    case (shape)
      ShapeSmall:  m = $urandom_range(0, 7);
      ShapeWide:   m = $urandom();
      ShapeZigzag: m = (idx % 2 == 0) ? mag_t'($urandom_range(0, 3)) : mag_t'($urandom());
      default: begin
        case ($urandom_range(0, 4))
          0:       m = '0;
          1:       m = '1;
          2:       m = 32'hFFFF_FFFE;
          3:       m = 32'd1;
          default: m = $urandom();
        endcase
      end
    endcase
    return m;
  endfunction

  task automatic send_random_run();
    int     len;
    int     pick;
    shape_e shape;
    pick = $urandom_range(0, 9);
    if (pick == 0)      len = $urandom_range(1, 3);
    else if (pick == 9) len = $urandom_range(17, 24);
    else                len = $urandom_range(4, 16);
    shape = shape_e'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       idle_odds = 0;
      1:       idle_odds = 1;
      default: idle_odds = 3;
    endcase
    for (int i = 0; i < len; i++) begin
      send_point(tag_t'($urandom()), pick_magnitude(shape, i), i == len - 1);
    end
    runs_sent++;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone point: short run, all slots zero
    send_listed_run(24'hFFFFFF, '{32'hFFFF_FFFF});
    // three points with a peak in the middle: still too short to report it
    send_listed_run(24'h000000, '{32'h0, 32'hFFFF_FFFF, 32'h0});
    // one peak at full scale; a rising last point never counts
    send_listed_run(24'hFFFFFE, '{32'h1, 32'hFFFF_FFFF, 32'h0, 32'h5});
    // ties keep arrival order, full list drops an equal peak and evicts for a larger one
    idle_odds = 3;
    send_listed_run(24'h5A0000, '{32'd0, 32'd7, 32'd0, 32'd9, 32'd0, 32'd7, 32'd0,
                                  32'd3, 32'd0, 32'd3, 32'd0, 32'd8, 32'd0, 32'd100});
    // flat plateau: no strict peak at all
    send_listed_run(24'h0F0F0F, '{32'd6, 32'd6, 32'd6, 32'd6});

    while (items_sent < RandomItems) send_random_run();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d runs, %0d points, %0d ranked results compared",
             runs_sent, points_checked, results_checked);
    $display("short runs, ties, full-list eviction and flat runs included, %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tflpp_pkg.sv
rtl/top_four_local_peak_picker.sv
verif/peak_list_checker.sv
verif/tb_top_four_local_peak_picker.sv
